[sv/avt_pkg.sv]
package avt_pkg;

    localparam int AVG_W        = 5;
    localparam int ANGLE_W      = 16;
    localparam int ACC_W        = 26;
    localparam int CORDIC_STEPS = 16;
    localparam int CSTEP_W      = 4;

    localparam logic [AVG_W-1:0]          AVG_RESET   = 5'd10;
    localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE = 16'sd23040;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SQRT,
        ST_CORDIC,
        ST_FIN
    } t_state;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ACC_W-1:0] atan_tab(input logic [CSTEP_W-1:0] i);
        logic signed [ACC_W-1:0] v;
        case (i)
            4'd0:    v = 26'sd2949120;
            4'd1:    v = 26'sd1740967;
            4'd2:    v = 26'sd919879;
            4'd3:    v = 26'sd466945;
            4'd4:    v = 26'sd234379;
            4'd5:    v = 26'sd117304;
            4'd6:    v = 26'sd58666;
            4'd7:    v = 26'sd29335;
            4'd8:    v = 26'sd14668;
            4'd9:    v = 26'sd7334;
            4'd10:   v = 26'sd3667;
            4'd11:   v = 26'sd1833;
            4'd12:   v = 26'sd917;
            4'd13:   v = 26'sd458;
            4'd14:   v = 26'sd229;
            4'd15:   v = 26'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/averaged_tilt_angles_core.sv]
// Averaged tilt angles. Each transfer on the sample channel adds one x/y/z
// sample into the window sums; the transfer that completes a window of
// avg_count samples (0 acts as 1, values above MAX_AVG act as MAX_AVG) starts
// the angle computation and produces one result: three tilt angles in 1/256
// degree and a flag for an all-zero mean vector. A sample that does not
// close a window only updates the sums and the sample count. A closing
// sample keeps the block busy while one shared restoring divider, one
// shared bit-serial square root and one shared 16-step CORDIC rotator
// are all used in turn. No sample is taken while a result waits to be
// transferred.
module averaged_tilt_angles_core #(
    parameter int SAMPLE_BITS = 13,
    parameter int MAX_AVG     = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]          i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]          i_accel_z,
    input  logic                                   i_cfg_we,
    input  logic [avt_pkg::AVG_W-1:0]              i_cfg_data,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [avt_pkg::ANGLE_W-1:0]     o_tilt_x,
    output logic signed [avt_pkg::ANGLE_W-1:0]     o_tilt_y,
    output logic signed [avt_pkg::ANGLE_W-1:0]     o_tilt_z,
    output logic                                   o_zero_vector
);
    import avt_pkg::*;

    localparam int CNT_W  = $clog2(MAX_AVG + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    // a shortened window can leave a mean as large as a full sum
    localparam int MAG_W  = SUM_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int RAD_W  = SQ_W + 1;
    localparam int RT_W   = (RAD_W + 16 + 1) / 2;
    localparam int RQ_W   = 2 * RT_W;
    localparam int CX_W   = RT_W + 3;
    localparam int STEP_W = $clog2(RT_W + 1);

    t_state r_state, n_state;

    logic [AVG_W-1:0]              r_avg;
    logic signed [SUM_W-1:0]       r_sum [3];
    logic [CNT_W-1:0]              r_samples;
    logic [STEP_W-1:0]             r_cnt;
    logic [1:0]                    r_k;
    logic [MAG_W-1:0]              r_mag [3];
    logic [2:0]                    r_neg;
    logic [SQ_W-1:0]               r_sq [3];
    logic [CNT_W-1:0]              r_rem;
    logic [SUM_W-1:0]              r_quo;
    logic [RQ_W-1:0]               r_sn, r_sr, r_sb;
    logic signed [CX_W-1:0]        r_cx, r_cy;
    logic signed [ACC_W-1:0]       r_acc;
    logic [RT_W-1:0]               r_num, r_den;
    logic signed [ANGLE_W-1:0]     r_tilt [3];
    logic                          r_ovalid;

    logic [CNT_W-1:0]              eff_cnt;
    logic                          accept, close_win;
    logic signed [SUM_W-1:0]       sum_next [3];
    logic signed [SUM_W-1:0]       cur_sum;
    logic [SUM_W-1:0]              abs_sum;
    logic [CNT_W+1:0]              d_sh, d_sub;
    logic [CNT_W-1:0]              rem_next;
    logic [SUM_W-1:0]              quo_next;
    logic [RAD_W-1:0]              rad;
    logic [RQ_W-1:0]               s_try, sn_next, sr_next;
    logic [RT_W-1:0]               abs_m, ang_num, ang_den;
    logic [CSTEP_W-1:0]            ci;
    logic signed [CX_W-1:0]        dx, dy;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [ANGLE_W-1:0]     res, tilt;
    logic                          last_div, last_sqrt, last_cordic;

    always_comb begin
        if (r_avg == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (int'(r_avg) > MAX_AVG) begin
            eff_cnt = CNT_W'(MAX_AVG);
        end else begin
            eff_cnt = CNT_W'(r_avg);
        end
    end

    assign accept    = i_valid && !o_stall;
    assign close_win = (CNT_W'(r_samples) + CNT_W'(1)) >= eff_cnt
                       || ((CNT_W + 1)'(r_samples) + (CNT_W + 1)'(1))
                          >= (CNT_W + 1)'(eff_cnt);

    assign sum_next[0] = r_sum[0] + SUM_W'(i_accel_x);
    assign sum_next[1] = r_sum[1] + SUM_W'(i_accel_y);
    assign sum_next[2] = r_sum[2] + SUM_W'(i_accel_z);

    // shared restoring divider, one quotient bit a cycle
    assign cur_sum  = r_sum[r_k];
    assign abs_sum  = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
    assign d_sh     = {1'b0, r_rem, r_quo[SUM_W-1]};
    assign d_sub    = d_sh - (CNT_W + 2)'(eff_cnt);
    assign rem_next = d_sub[CNT_W+1] ? d_sh[CNT_W-1:0] : d_sub[CNT_W-1:0];
    assign quo_next = {r_quo[SUM_W-2:0], ~d_sub[CNT_W+1]};

    // radicand and operands for the angle in hand
    always_comb begin
        case (r_k)
            2'd0:    rad = RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
            2'd1:    rad = RAD_W'(r_sq[0]) + RAD_W'(r_sq[2]);
            default: rad = RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]);
        endcase
    end

    assign abs_m   = RT_W'({r_mag[r_k], 8'b0});
    assign ang_num = (r_k == 2'd2) ? r_sr[RT_W-1:0] : abs_m;
    assign ang_den = (r_k == 2'd2) ? abs_m : r_sr[RT_W-1:0];

    // shared square root, one result bit a cycle
    assign s_try   = r_sr + r_sb;
    assign sn_next = (r_sn >= s_try) ? r_sn - s_try : r_sn;
    assign sr_next = (r_sn >= s_try) ? (r_sr >> 1) + r_sb : r_sr >> 1;

    // shared CORDIC stage, vectoring mode
    assign ci = CSTEP_W'(r_cnt - STEP_W'(1));
    assign dx = r_cy >>> ci;
    assign dy = r_cx >>> ci;

    always_comb begin
        rnd = (r_acc + ACC_W'(128)) >>> 8;
        if (r_num == '0) begin
            res = '0;
        end else if (r_den == '0) begin
            res = RIGHT_ANGLE;
        end else if (rnd < 0) begin
            res = '0;
        end else if (rnd > ACC_W'(RIGHT_ANGLE)) begin
            res = RIGHT_ANGLE;
        end else begin
            res = ANGLE_W'(rnd);
        end
        tilt = r_neg[r_k] ? -res : res;
    end

    assign last_div    = r_cnt == STEP_W'(SUM_W);
    assign last_sqrt   = r_cnt == STEP_W'(RT_W);
    assign last_cordic = r_cnt == STEP_W'(CORDIC_STEPS);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept && close_win) n_state = ST_DIV;
            ST_DIV:    if (last_div && r_k == 2'd2) n_state = ST_MUL;
            ST_MUL:    if (r_k == 2'd2) n_state = ST_SQRT;
            ST_SQRT:   if (last_sqrt) n_state = ST_CORDIC;
            ST_CORDIC: if (last_cordic) n_state = ST_FIN;
            ST_FIN:    n_state = (r_k == 2'd2) ? ST_IDLE : ST_SQRT;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE) || r_ovalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_avg     <= AVG_RESET;
            r_samples <= '0;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
            r_k       <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_avg <= i_cfg_data;
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_k   <= '0;
                    if (accept) begin
                        for (int a = 0; a < 3; a++) begin
                            r_sum[a] <= sum_next[a];
                        end
                        r_samples <= close_win ? '0 : r_samples + CNT_W'(1);
                    end
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_quo <= abs_sum;
                        r_rem <= '0;
                        r_cnt <= r_cnt + STEP_W'(1);
                    end else begin
                        r_quo <= quo_next;
                        r_rem <= rem_next;
                        if (last_div) begin
                            r_mag[r_k] <= MAG_W'(quo_next);
                            r_neg[r_k] <= cur_sum[SUM_W-1] && (quo_next != '0);
                            r_cnt      <= '0;
                            if (r_k == 2'd2) begin
                                r_k <= '0;
                                for (int a = 0; a < 3; a++) begin
                                    r_sum[a] <= '0;
                                end
                            end else begin
                                r_k <= r_k + 2'd1;
                            end
                        end else begin
                            r_cnt <= r_cnt + STEP_W'(1);
                        end
                    end
                end
                ST_MUL: begin
                    r_sq[r_k] <= r_mag[r_k] * r_mag[r_k];
                    r_k       <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
                ST_SQRT: begin
                    if (r_cnt == '0) begin
                        r_sn  <= RQ_W'(rad) << 16;
                        r_sr  <= '0;
                        r_sb  <= RQ_W'(1) << (RQ_W - 2);
                        r_cnt <= r_cnt + STEP_W'(1);
                    end else begin
                        r_sn  <= sn_next;
                        r_sr  <= sr_next;
                        r_sb  <= r_sb >> 2;
                        r_cnt <= last_sqrt ? '0 : r_cnt + STEP_W'(1);
                    end
                end
                ST_CORDIC: begin
                    if (r_cnt == '0) begin
                        r_num <= ang_num;
                        r_den <= ang_den;
                        r_cx  <= CX_W'(ang_den);
                        r_cy  <= CX_W'(ang_num);
                        r_acc <= '0;
                        r_cnt <= r_cnt + STEP_W'(1);
                    end else begin
                        if (!r_cy[CX_W-1]) begin
                            r_cx  <= r_cx + dx;
                            r_cy  <= r_cy - dy;
                            r_acc <= r_acc + atan_tab(ci);
                        end else begin
                            r_cx  <= r_cx - dx;
                            r_cy  <= r_cy + dy;
                            r_acc <= r_acc - atan_tab(ci);
                        end
                        r_cnt <= last_cordic ? '0 : r_cnt + STEP_W'(1);
                    end
                end
                ST_FIN: begin
                    r_tilt[r_k] <= tilt;
                    if (r_k == 2'd2) begin
                        r_k           <= '0;
                        r_ovalid      <= 1'b1;
                        o_tilt_x      <= r_tilt[0];
                        o_tilt_y      <= r_tilt[1];
                        o_tilt_z      <= tilt;
                        o_zero_vector <= (r_mag[0] == '0) && (r_mag[1] == '0)
                                         && (r_mag[2] == '0);
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    assign o_valid = r_ovalid;

    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_vector |-> o_tilt_x == '0 && o_tilt_y == '0 && o_tilt_z == '0)
        else $error("zero vector with non-zero angle");

    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tilt_x <= RIGHT_ANGLE && o_tilt_x >= -RIGHT_ANGLE
                 && o_tilt_z <= RIGHT_ANGLE && o_tilt_z >= -RIGHT_ANGLE)
        else $error("tilt out of range");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_samples) < MAX_AVG)
        else $error("sample count past window limit");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE && r_state != ST_FIN |=> !$rose(r_ovalid))
        else $error("result raised outside final step");

endmodule
